/* design/distance_vector_route_table_assert.svh */
// Assertion macros for the route table
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH
// implication checked on every edge outside reset
`define DVRT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// condition that must always hold outside reset
`define DVRT_ASSERT_ALW(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`endif

/* design/dvrt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrt_pkg
// Types and codes shared by the route table modules.
// ----------------------------------------------------------------------------
package dvrt_pkg;
  localparam logic [2:0] FUNC_ADV  = 3'd0;
  localparam logic [2:0] FUNC_TICK = 3'd1;
  localparam logic [2:0] FUNC_DOWN = 3'd2;
  localparam logic [2:0] FUNC_LOOK = 3'd3;
  localparam logic [2:0] FUNC_DUMP = 3'd4;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_REQ    = 2'd1;
  localparam logic [1:0] KIND_DUMP   = 2'd2;

  localparam logic [0:0] REG_INF_COST = 1'd0;
  localparam logic [0:0] REG_TIMEOUT  = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_SHIFT, ST_WRITE, ST_RESULT, ST_DUMP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input word
    logic scan_clr;   // reset scan index to 0
    logic scan_inc;   // step scan index
    logic scan_op;    // apply per-slot update for tick/down at scan index
    logic shift_init; // latch insert slot, move index to route count
    logic mark_full;  // advertise found no room
    logic shift;      // move slot idx-1 into idx, step down
    logic ins;        // write new route at insert position
    logic upd;        // refresh found route
    logic res_load;   // build status result
    logic dump_load;  // build dump result at scan index
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] func;
    logic       scan_end;  // scan index reached route count
    logic       hit;       // current slot matches address
    logic       stop;      // current slot key > address (insert point)
    logic       full;
    logic       shift_end; // shift index at insert position
    logic       out_busy;  // output register holds a word the sink is not taking
  } stat_t;
endpackage

/* design/dvrt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrt_in_if / dvrt_out_if
// Valid/ready channels carrying the request and result words.
// ----------------------------------------------------------------------------
interface dvrt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] route_address;
  logic [7:0]  adv_cost;
  logic [7:0]  interface_req;
  modport source (output valid, func, route_address, adv_cost, interface_req,
                  input ready);
  modport sink (input valid, func, route_address, adv_cost, interface_req,
                output ready);
endinterface

interface dvrt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_address;
  logic [7:0]  out_cost;
  logic [7:0]  out_next_hop;
  logic        entry_found;
  logic        table_full;
  logic [5:0]  entry_count;
  logic [1:0]  message_kind;
  logic        last;
  modport source (output valid, out_address, out_cost, out_next_hop, entry_found,
                  table_full, entry_count, message_kind, last, input ready);
  modport sink (input valid, out_address, out_cost, out_next_hop, entry_found,
                table_full, entry_count, message_kind, last, output ready);
endinterface

/* design/dvrt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrt_ctrl
// Sequencer: scans the table, shifts for inserts and emits result words.
// ----------------------------------------------------------------------------
module dvrt_ctrl
  import dvrt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);
  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SCAN;
      ST_SCAN: begin
        if (stat.func == FUNC_ADV) begin
          if (stat.hit) state_next = ST_RESULT;
          else if (stat.scan_end || stat.stop)
            state_next = stat.full ? ST_RESULT : ST_SHIFT;
        end else if (stat.func == FUNC_LOOK) begin
          if (stat.scan_end || stat.hit) state_next = ST_RESULT;
        end else if (stat.func == FUNC_DUMP) begin
          state_next = stat.scan_end ? ST_RESULT : ST_DUMP;
        end else if (stat.func == FUNC_TICK || stat.func == FUNC_DOWN) begin
          if (stat.scan_end) state_next = ST_RESULT;
        end else state_next = ST_RESULT;
      end
      ST_SHIFT: if (stat.shift_end) state_next = ST_WRITE;
      ST_WRITE: state_next = ST_RESULT;
      ST_RESULT: if (!stat.out_busy) state_next = ST_IDLE;
      ST_DUMP: if (stat.scan_end) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        cmd.scan_clr = in_valid;
      end
      ST_SCAN: begin
        if (stat.func == FUNC_ADV) begin
          if (stat.hit) cmd.upd = 1'b1;
          else if (stat.scan_end || stat.stop) begin
            if (stat.full) cmd.mark_full = 1'b1;
            else cmd.shift_init = 1'b1;
          end else cmd.scan_inc = 1'b1;
        end else if (stat.func == FUNC_LOOK) begin
          if (!(stat.scan_end || stat.hit)) cmd.scan_inc = 1'b1;
        end else if (stat.func == FUNC_TICK || stat.func == FUNC_DOWN) begin
          if (!stat.scan_end) begin
            cmd.scan_op = 1'b1;
            cmd.scan_inc = 1'b1;
          end
        end
      end
      ST_SHIFT: cmd.shift = !stat.shift_end;
      ST_WRITE: cmd.ins = 1'b1;
      ST_RESULT: cmd.res_load = !stat.out_busy;
      ST_DUMP: if (!stat.scan_end && !stat.out_busy) begin
        cmd.dump_load = 1'b1;
        cmd.scan_inc = 1'b1;
      end
      default: ;
    endcase
  end
endmodule

/* design/dvrt_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrt_datapath
// Route slots, scan/shift index, config registers and result register.
// ----------------------------------------------------------------------------
module dvrt_datapath
  import dvrt_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_address,
  input  logic [7:0]  in_cost,
  input  logic [7:0]  in_ifc,
  dvrt_out_if.source  out
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [31:0] keys  [ENTRIES];
  logic [7:0]  costs [ENTRIES];
  logic [7:0]  hops  [ENTRIES];
  logic [15:0] ttls  [ENTRIES];
  logic [CW-1:0] total, idx, pos;
  logic [7:0]  inf_cost;
  logic [15:0] timeout_ticks;
  logic [2:0]  func;
  logic [31:0] addr;
  logic [7:0]  nc, ifc;
  logic        ovalid, hit_seen, fullflag;
  logic [IW-1:0] ix, ixm1;
  logic [15:0] ttl_dec;
  logic [7:0]  pc;
  logic [31:0] res_address;
  logic [7:0]  res_cost, res_hop;
  logic        res_found, res_full, res_last;
  logic [1:0]  res_kind;

  assign ix   = idx[IW-1:0];
  assign ixm1 = IW'(idx - CW'(1));
  assign ttl_dec = (ttls[ix] != 16'd0) ? ttls[ix] - 16'd1 : 16'd0;
  assign pc = (inf_cost == 8'hFF) ? 8'hFF : inf_cost + 8'd1;

  // status
  always_comb begin
    stat.func      = func;
    stat.scan_end  = (idx >= total);
    stat.hit       = (idx < total) && (keys[ix] == addr);
    stat.stop      = (idx < total) && (keys[ix] > addr);
    stat.full      = (total >= CW'(ENTRIES));
    stat.shift_end = (idx == pos);
    stat.out_busy  = ovalid && !out.ready;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inf_cost <= 8'd16;
      timeout_ticks <= 16'd180;
    end else if (cfg_we) begin
      if (cfg_index == REG_INF_COST) inf_cost <= cfg_data[7:0];
      else if (cfg_index == REG_TIMEOUT) timeout_ticks <= cfg_data;
    end
  end

  // request capture, scan/shift index, insert slot and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      idx <= '0;
      pos <= '0;
      hit_seen <= 1'b0;
      fullflag <= 1'b0;
    end else begin
      if (cmd.load) begin
        func <= in_func;
        addr <= in_address;
        nc <= (in_cost == 8'hFF) ? 8'hFF : in_cost + 8'd1;
        ifc <= in_ifc;
      end
      // shift walks from the route count down to the insert slot
      if (cmd.scan_clr) idx <= '0;
      else if (cmd.shift_init) idx <= total;
      else if (cmd.scan_inc) idx <= idx + CW'(1);
      else if (cmd.shift) idx <= idx - CW'(1);
      if (cmd.shift_init) pos <= idx;
      if (cmd.load) hit_seen <= 1'b0;
      else if (cmd.upd) hit_seen <= 1'b1;
      if (cmd.load) fullflag <= 1'b0;
      else if (cmd.mark_full) fullflag <= 1'b1;
      if (cmd.ins) total <= total + CW'(1);
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (cmd.upd && costs[ix] >= nc) begin
      costs[ix] <= nc;
      hops[ix] <= ifc;
      ttls[ix] <= timeout_ticks;
    end
    if (cmd.scan_op) begin
      if (func == FUNC_TICK) begin
        ttls[ix] <= ttl_dec;
        if (ttl_dec == 16'd0) costs[ix] <= inf_cost;
      end else if (hops[ix] == ifc) begin
        costs[ix] <= pc;
      end
    end
    if (cmd.shift) begin
      keys[ix]  <= keys[ixm1];
      costs[ix] <= costs[ixm1];
      hops[ix]  <= hops[ixm1];
      ttls[ix]  <= ttls[ixm1];
    end
    if (cmd.ins) begin
      keys[IW'(pos)]  <= addr;
      costs[IW'(pos)] <= nc;
      hops[IW'(pos)]  <= ifc;
      ttls[IW'(pos)]  <= timeout_ticks;
    end
  end

  // next result word
  always_comb begin
    res_address = '0;
    res_cost = '0;
    res_hop = '0;
    res_found = 1'b0;
    res_full = 1'b0;
    res_kind = KIND_STATUS;
    res_last = 1'b1;
    if (cmd.dump_load) begin
      res_address = keys[ix];
      res_cost = costs[ix];
      res_hop = hops[ix];
      res_found = 1'b1;
      res_kind = KIND_DUMP;
      res_last = (idx + CW'(1) >= total);
    end else begin
      case (func)
        FUNC_ADV: begin
          res_address = addr;
          if (fullflag) res_full = 1'b1;
          else if (hit_seen) begin
            res_cost = costs[ix];
            res_hop = hops[ix];
          end else begin
            res_cost = nc;
            res_hop = ifc;
          end
        end
        FUNC_DOWN: begin
          res_hop = ifc;
          res_kind = KIND_REQ;
        end
        FUNC_LOOK: begin
          res_address = addr;
          if (idx < total) begin
            res_cost = costs[ix];
            res_hop = hops[ix];
            res_found = 1'b1;
          end
        end
        FUNC_DUMP: res_kind = KIND_DUMP;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) ovalid <= 1'b0;
    else if (cmd.res_load || cmd.dump_load) ovalid <= 1'b1;
    else if (out.ready) ovalid <= 1'b0;
    if (cmd.res_load || cmd.dump_load) begin
      out.out_address <= res_address;
      out.out_cost <= res_cost;
      out.out_next_hop <= res_hop;
      out.entry_found <= res_found;
      out.table_full <= res_full;
      out.entry_count <= 6'(total);
      out.message_kind <= res_kind;
      out.last <= res_last;
    end
  end
  assign out.valid = ovalid;

  `include "distance_vector_route_table_assert.svh"
  `DVRT_ASSERT_ALW(a_total_range, total <= CW'(ENTRIES))
  `DVRT_ASSERT_IMP(a_ins_room, cmd.ins, total < CW'(ENTRIES))
  `DVRT_ASSERT_IMP(a_one_load, cmd.res_load, !cmd.dump_load)
endmodule

/* design/distance_vector_route_table.sv */
`timescale 1ns / 1ps
// The scan visits one slot a cycle and, for a sorted insert, the shift moves one
// slot a cycle. A new request is taken only in idle, after the result word of the
// previous one has been loaded for output; a dump emits one word per cycle while
// the sink is ready.
// Reset: synchronous, active high; empties the table, infinity 16, ttl 180.
// ----------------------------------------------------------------------------
// distance_vector_route_table
// Sorted distance-vector route table with controller and datapath.
// ----------------------------------------------------------------------------
module distance_vector_route_table
  import dvrt_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  dvrt_in_if.sink     in_ch,
  dvrt_out_if.source  out_ch
);
  cmd_t  cmd;
  stat_t stat;

  dvrt_ctrl u_ctrl (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .stat, .cmd
  );

  dvrt_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk, .rst, .cmd, .stat, .cfg_we, .cfg_index, .cfg_data,
    .in_func(in_ch.func), .in_address(in_ch.route_address),
    .in_cost(in_ch.adv_cost), .in_ifc(in_ch.interface_req), .out(out_ch)
  );
endmodule

/* sim/dvrt_route_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrt_route_checker
// Watches the request and result channels of the route table, keeps its own
// copy of the sorted table, predicts every result word and compares.
// ----------------------------------------------------------------------------
module dvrt_route_checker
  import dvrt_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  dvrt_in_if          in_mon,
  dvrt_out_if         out_mon,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] address;
    logic [7:0]  cost;
    logic [7:0]  hop;
    logic        found;
    logic        full;
    logic [5:0]  count;
    logic [1:0]  kind;
    logic        last;
  } route_word_t;

  logic [31:0] tbl_key [ENTRIES];
  logic [7:0]  tbl_cost[ENTRIES];
  logic [7:0]  tbl_hop [ENTRIES];
  logic [15:0] tbl_ttl [ENTRIES];
  int          tbl_total;
  logic [7:0]  infinity;
  logic [15:0] ttl_reload;
  route_word_t expected_words[$];

  assign pending = expected_words.size();

  function automatic route_word_t mk(logic [31:0] a, logic [7:0] c, logic [7:0] h,
                                     logic f, logic fl, logic [1:0] k, logic l);
    route_word_t w;
    w = '{a, c, h, f, fl, tbl_total[5:0], k, l};
    return w;
  endfunction

  // append one predicted word
  task automatic queue_word(route_word_t w);
    expected_words = {expected_words, w};
  endtask

  // update the table for one request and queue its result words
  task automatic apply_request(logic [2:0] fn, logic [31:0] addr, logic [7:0] acost,
                               logic [7:0] ifc);
    int slot;
    int pos;
    logic [8:0] nc;
    logic [8:0] pc;
    slot = -1;
    for (int i = 0; i < tbl_total; i++)
      if (tbl_key[i] == addr && slot < 0) slot = i;
    case (fn)
      FUNC_ADV: begin
        nc = (acost == 8'hff) ? 9'd255 : acost + 9'd1;
        if (slot >= 0) begin
          if (tbl_cost[slot] >= nc[7:0]) begin
            tbl_cost[slot] = nc[7:0];
            tbl_hop[slot] = ifc;
            tbl_ttl[slot] = ttl_reload;
          end
          queue_word(mk(addr, tbl_cost[slot], tbl_hop[slot], 0, 0, KIND_STATUS, 1));
        end else if (tbl_total >= ENTRIES) begin
          queue_word(mk(addr, 0, 0, 0, 1, KIND_STATUS, 1));
        end else begin
          pos = 0;
          while (pos < tbl_total && tbl_key[pos] < addr) pos++;
          for (int i = tbl_total; i > pos; i--) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_cost[i] = tbl_cost[i-1];
            tbl_hop[i] = tbl_hop[i-1];
            tbl_ttl[i] = tbl_ttl[i-1];
          end
          tbl_key[pos] = addr;
          tbl_cost[pos] = nc[7:0];
          tbl_hop[pos] = ifc;
          tbl_ttl[pos] = ttl_reload;
          tbl_total++;
          queue_word(mk(addr, nc[7:0], ifc, 0, 0, KIND_STATUS, 1));
        end
      end
      FUNC_TICK: begin
        for (int i = 0; i < tbl_total; i++) begin
          if (tbl_ttl[i] != 0) tbl_ttl[i]--;
          if (tbl_ttl[i] == 0) tbl_cost[i] = infinity;
        end
        queue_word(mk(0, 0, 0, 0, 0, KIND_STATUS, 1));
      end
      FUNC_DOWN: begin
        pc = (infinity == 8'hff) ? 9'd255 : infinity + 9'd1;
        for (int i = 0; i < tbl_total; i++)
          if (tbl_hop[i] == ifc) tbl_cost[i] = pc[7:0];
        queue_word(mk(0, 0, ifc, 0, 0, KIND_REQ, 1));
      end
      FUNC_LOOK: begin
        if (slot >= 0)
          queue_word(mk(addr, tbl_cost[slot], tbl_hop[slot], 1, 0, KIND_STATUS, 1));
        else
          queue_word(mk(addr, 0, 0, 0, 0, KIND_STATUS, 1));
      end
      FUNC_DUMP: begin
        if (tbl_total == 0)
          queue_word(mk(0, 0, 0, 0, 0, KIND_DUMP, 1));
        for (int i = 0; i < tbl_total; i++)
          queue_word(mk(tbl_key[i], tbl_cost[i], tbl_hop[i], 1, 0,
                        KIND_DUMP, i == tbl_total - 1));
      end
      default: queue_word(mk(0, 0, 0, 0, 0, KIND_STATUS, 1));
    endcase
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    route_word_t got;
    route_word_t exp_w;
    if (rst) begin
      tbl_total <= 0;
      infinity <= 8'd16;
      ttl_reload <= 16'd180;
      fail_count <= 0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_INF_COST) infinity <= cfg_data[7:0];
        else ttl_reload <= cfg_data;
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.out_address, out_mon.out_cost, out_mon.out_next_hop,
                out_mon.entry_found, out_mon.table_full, out_mon.entry_count,
                out_mon.message_kind, out_mon.last};
        if (expected_words.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result word %h", got);
        end else begin
          exp_w = expected_words.pop_front();
          if (got !== exp_w) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected %h actual %h", exp_w, got);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        apply_request(in_mon.func, in_mon.route_address, in_mon.adv_cost,
                      in_mon.interface_req);
    end
  end

endmodule

/* sim/distance_vector_route_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_vector_route_table_tb
// Drives directed and random route requests with random gaps and stalls,
// changes the registers between phases; the checker judges every word.
// ----------------------------------------------------------------------------
module distance_vector_route_table_tb
  import dvrt_pkg::*;
;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;
  int          hold_off;
  logic [31:0] addr_pool[8];

  dvrt_in_if  in_ch();
  dvrt_out_if out_ch();

  distance_vector_route_table u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  dvrt_route_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("distance_vector_route_table verification failed");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 0;
    @(negedge clk);
    forever begin
      if (hold_off > 0) begin
        out_ch.ready <= 0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end
      out_ch.ready <= 1;
      @(negedge clk);
      if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 0;
        repeat (gap_len() + 1) @(negedge clk);
      end
    end
  end

  task automatic send(logic [2:0] fn, logic [31:0] a, logic [7:0] c, logic [7:0] h,
                      bit gaps);
    in_ch.valid <= 1;
    in_ch.func <= fn;
    in_ch.route_address <= a;
    in_ch.adv_cost <= c;
    in_ch.interface_req <= h;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (gaps && gap_len() > 0) begin
      in_ch.valid <= 0;
      repeat (gap_len()) @(negedge clk);
    end
  endtask

  task automatic drain_and_write(logic [0:0] idx, logic [15:0] val);
    in_ch.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_item();
    logic [2:0]  fn;
    logic [31:0] a;
    int r;
    r = $urandom_range(0, 99);
    a = ($urandom_range(0, 3) == 0) ? $urandom() : addr_pool[$urandom_range(0, 7)];
    if (r < 45) fn = FUNC_ADV;
    else if (r < 60) fn = FUNC_TICK;
    else if (r < 70) fn = FUNC_DOWN;
    else if (r < 88) fn = FUNC_LOOK;
    else if (r < 95) fn = FUNC_DUMP;
    else fn = 3'($urandom_range(5, 7));
    send(fn, a, 8'($urandom()), 8'($urandom_range(0, 3) == 0 ? $urandom() :
         $urandom_range(0, 3)), 1);
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = REG_INF_COST;
    cfg_data = 0;
    hold_off = 0;
    in_ch.valid = 0;
    in_ch.func = FUNC_ADV;
    in_ch.route_address = 0;
    in_ch.adv_cost = 0;
    in_ch.interface_req = 0;
    foreach (addr_pool[i]) addr_pool[i] = $urandom();
    addr_pool[0] = 32'h0;
    addr_pool[1] = 32'hffff_ffff;
    repeat (6) @(negedge clk);
    rst = 0;

    // directed: empty table, extremes, every function
    send(FUNC_DUMP, 0, 0, 0, 0);
    send(FUNC_LOOK, 32'h1234, 0, 0, 0);
    send(FUNC_ADV, 32'hffff_ffff, 8'hff, 8'hff, 0);
    send(FUNC_ADV, 32'h0, 8'h00, 8'h00, 0);
    send(FUNC_ADV, 32'h8000_0000, 8'h05, 8'h01, 0);
    send(FUNC_ADV, 32'h8000_0000, 8'h09, 8'h02, 0);
    send(FUNC_ADV, 32'h8000_0000, 8'h02, 8'h03, 0);
    send(FUNC_LOOK, 32'h8000_0000, 0, 0, 0);
    send(FUNC_DOWN, 0, 0, 8'h03, 0);
    send(FUNC_TICK, 0, 0, 0, 0);
    send(3'd5, 32'hdead_beef, 8'h55, 8'haa, 0);
    send(3'd7, 0, 0, 0, 0);
    send(FUNC_DUMP, 0, 0, 0, 0);

    // short ttl so ticks expire routes, then a high infinity of 254
    drain_and_write(REG_TIMEOUT, 16'd1);
    drain_and_write(REG_INF_COST, 8'd254);
    send(FUNC_ADV, 32'h10, 8'h01, 8'h07, 0);
    send(FUNC_TICK, 0, 0, 0, 0);
    send(FUNC_DOWN, 0, 0, 8'h07, 0);
    send(FUNC_DUMP, 0, 0, 0, 0);

    // fill the table past capacity, with the result side held off
    hold_off = 400;
    for (int i = 0; i < 34; i++)
      send(FUNC_ADV, 32'($urandom()), 8'($urandom_range(0, 20)), 8'(i % 4), 0);
    send(FUNC_DUMP, 0, 0, 0, 0);

    drain_and_write(REG_INF_COST, 8'd1);
    drain_and_write(REG_TIMEOUT, 16'd65535);
    repeat (25) random_item();
    drain_and_write(REG_INF_COST, 8'd16);
    drain_and_write(REG_TIMEOUT, 16'd3);
    repeat (25) random_item();

    in_ch.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0)
      $display("distance_vector_route_table verification clean");
    else
      $display("distance_vector_route_table verification failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/dvrt_pkg.sv
design/dvrt_if.sv
design/dvrt_ctrl.sv
design/dvrt_datapath.sv
design/distance_vector_route_table.sv
sim/dvrt_route_checker.sv
sim/distance_vector_route_table_tb.sv
